>>> design/firch_pkg.sv
// Shared types and constants for the circular-history FIR filter.
package firch_pkg;

  localparam int MAX_TAPS    = 1024;
  localparam int SAMPLE_BITS = 32;

  localparam int TAP_AW   = $clog2(MAX_TAPS);
  localparam int CNT_W    = TAP_AW + 1;
  localparam int TAPS_W   = 11;
  localparam int CMPT_W   = (CNT_W > TAPS_W) ? CNT_W : TAPS_W;
  localparam int CIDX_W   = (TAP_AW >= 10) ? TAP_AW + 1 : 11;
  localparam int PROD_W   = 64;
  localparam int ACC_W    = PROD_W + TAP_AW + 1;

  localparam logic [TAPS_W-1:0] TAPS_RESET = TAPS_W'(32);
  localparam logic [31:0]       KEEP_MASK  = 32'hFFFF_FFFF << (32 - SAMPLE_BITS);
  localparam logic [ACC_W-1:0]  ROUND_BIAS = ACC_W'(1) << 30;

  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic {
    CMD_FILTER = 1'b0,
    CMD_LOAD   = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [9:0]         coef_index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] filtered_sample;
    logic               saturated;
  } out_item_t;

endpackage

>>> design/fir_filter_circular_history.sv
// Direct-form FIR filter, Q1.31, with a circular sample history and a shared MAC.
//
// Input channel (in_valid/in_stall/in_data) carries transactions of two kinds:
// a coefficient load writes one table entry in the accept cycle and gives no
// result; a sample runs the filter and gives one output transaction on the
// out_valid/out_stall/out_data channel. cfg_we/cfg_wdata write the tap count n.
// One multiply-accumulate unit serves every tap, one tap per cycle, behind a
// registered memory read and a registered product. A sample passes from accept
// through ST_LOAD, ST_MAC and ST_DRAIN to ST_DONE, which writes the output
// register; in_stall is high until then, so no transaction is taken meanwhile.
// Coefficient loads are taken one per cycle while idle.
// After rst_n is released the history memory is cleared, one entry per cycle,
// through all MAX_TAPS (1024) entries; in_stall is high during that pass, while
// configuration writes are taken. Coefficients are undefined until loaded.
// A finished result waits in the output register while out_stall is high; the
// block takes the next transaction meanwhile and holds its own result until
// the output register is free.
module fir_filter_circular_history (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  firch_pkg::in_item_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output firch_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [firch_pkg::TAPS_W-1:0] cfg_wdata
);
  import firch_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_MAC,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t                    state_r;
  logic [TAPS_W-1:0]         taps_r;
  logic [TAP_AW-1:0]         clr_addr_r;
  logic [TAP_AW-1:0]         head_r;
  logic [CNT_W-1:0]          n_r;
  logic [CNT_W-1:0]          j_r;
  logic [TAP_AW-1:0]         pos_r;
  logic [31:0]               sample_r;
  logic                      rd_vld_r;
  logic                      mul_vld_r;
  logic signed [31:0]        hist_rd_r;
  logic signed [31:0]        coef_rd_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic [ACC_W-1:0]          acc_r;
  logic                      out_valid_r;
  out_item_t                 out_data_r;

  logic [31:0]               hist_mem [MAX_TAPS];
  logic [31:0]               coef_mem [MAX_TAPS];

  logic                      in_accept;
  logic [CMPT_W-1:0]         taps_ext;
  logic [CNT_W-1:0]          n_eff;
  logic [TAP_AW-1:0]         head_eff;
  logic [CIDX_W-1:0]         idx_ext;
  logic                      coef_we;
  logic                      hist_we;
  logic [TAP_AW-1:0]         hist_wa;
  logic [31:0]               hist_wd;
  logic                      last_tap;
  logic                      pos_wrap;
  logic                      issue;
  logic [ACC_W-64:0]         acc_top;
  logic                      in_range;
  logic                      out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    taps_ext = CMPT_W'(taps_r);
    if (taps_ext == '0) begin
      n_eff = CNT_W'(1);
    end else if (taps_ext > CMPT_W'(MAX_TAPS)) begin
      n_eff = CNT_W'(MAX_TAPS);
    end else begin
      n_eff = taps_ext[CNT_W-1:0];
    end
    if (CNT_W'(head_r) >= n_eff) begin
      head_eff = TAP_AW'(n_eff - CNT_W'(1));
    end else begin
      head_eff = head_r;
    end
  end

  assign idx_ext = CIDX_W'(in_data.coef_index);
  assign coef_we = in_accept && (in_data.cmd == CMD_LOAD) &&
                   (idx_ext < CIDX_W'(MAX_TAPS));

  always_comb begin
    hist_we = 1'b0;
    hist_wa = clr_addr_r;
    hist_wd = '0;
    if (state_r == ST_CLEAR) begin
      hist_we = 1'b1;
    end else if (state_r == ST_LOAD) begin
      hist_we = 1'b1;
      hist_wa = head_eff;
      hist_wd = sample_r;
    end
  end

  assign issue    = (state_r == ST_MAC);
  assign last_tap = (j_r == n_r - CNT_W'(1));
  assign pos_wrap = (CNT_W'(pos_r) + CNT_W'(1)) >= n_r;
  assign acc_top  = acc_r[ACC_W-1:63];
  assign in_range = (&acc_r[ACC_W-1:62]) || !(|acc_r[ACC_W-1:62]);
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    if (coef_we) begin
      coef_mem[idx_ext[TAP_AW-1:0]] <= in_data.value & KEEP_MASK;
    end
    hist_rd_r <= hist_mem[pos_r];
    coef_rd_r <= coef_mem[j_r[TAP_AW-1:0]];
    prod_r    <= hist_rd_r * coef_rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r <= TAPS_RESET;
    end else if (cfg_we) begin
      taps_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      head_r      <= '0;
      rd_vld_r    <= 1'b0;
      mul_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r  <= issue;
      mul_vld_r <= rd_vld_r;
      if (mul_vld_r) begin
        acc_r <= acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
      end
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + TAP_AW'(1);
          if (clr_addr_r == TAP_AW'(MAX_TAPS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept && (in_data.cmd == CMD_FILTER)) begin
            sample_r <= in_data.value & KEEP_MASK;
            state_r  <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          n_r     <= n_eff;
          head_r  <= head_eff;
          pos_r   <= head_eff;
          j_r     <= '0;
          acc_r   <= ROUND_BIAS;
          state_r <= ST_MAC;
        end
        ST_MAC: begin
          j_r   <= j_r + CNT_W'(1);
          pos_r <= pos_wrap ? '0 : pos_r + TAP_AW'(1);
          if (last_tap) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_vld_r && !mul_vld_r) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (in_range) begin
              out_data_r.filtered_sample <= acc_r[62:31];
              out_data_r.saturated       <= 1'b0;
            end else begin
              out_data_r.filtered_sample <= acc_top[ACC_W-64] ? SAT_NEG : SAT_POS;
              out_data_r.saturated       <= 1'b1;
            end
            head_r  <= (head_r == '0) ? TAP_AW'(n_r - CNT_W'(1)) : head_r - TAP_AW'(1);
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("output raised outside completion");

  a_tap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC) |-> (j_r < n_r) && (CNT_W'(pos_r) < n_r))
    else $error("tap counter or history position beyond tap count");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_data.cmd == CMD_LOAD)) |=> (state_r == ST_IDLE))
    else $error("coefficient load started a filter pass");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.saturated) |->
      (out_data_r.filtered_sample == SAT_POS) || (out_data_r.filtered_sample == SAT_NEG))
    else $error("saturated output not at a bound");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> !rd_vld_r && !mul_vld_r)
    else $error("MAC pipeline busy at completion");
`endif

endmodule
